// ----- rtl/assert_macros.svh -----
// assertion macros used by int_bubble_sort.sv, the rtl file that checks its own logic
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

// ----- rtl/ibs_pkg.sv -----
// shared types and constants for the integer bubble sort block
// no dependencies; used by ibs_dpath, ibs_ctrl and int_bubble_sort
package ibs_pkg;

  localparam int MAX_ELEMS_DEF = 16;
  localparam int DATA_W        = 32;

  // input transfer payload
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_item;
  } in_t;

  // result transfer payload
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_result;
    logic                     overflowed;
  } out_t;

  // source of the buffer write data
  typedef enum logic [1:0] {
    WSEL_IN    = 2'd0,
    WSEL_MIN   = 2'd1,
    WSEL_CARRY = 2'd2
  } wsel_t;

  // controller to datapath commands
  typedef struct packed {
    logic  ram_we;
    wsel_t wsel;
    logic  ram_re;
    logic  carry_first;
    logic  carry_step;
    logic  out_load;
    logic  out_last;
    logic  out_ovf;
    logic  out_clear;
  } dp_cmd_t;

endpackage

// ----- rtl/ibs_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module ibs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/ibs_dpath.sv -----
// datapath: element buffer, bubble carry register and result register
// depends on ibs_pkg and ibs_ram
module ibs_dpath #(
  parameter int MAX_ELEMS = ibs_pkg::MAX_ELEMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ibs_pkg::DATA_W-1:0]   in_value,
  input  ibs_pkg::dp_cmd_t             cmd,
  input  logic [$clog2(MAX_ELEMS)-1:0] ram_waddr,
  input  logic [$clog2(MAX_ELEMS)-1:0] ram_raddr,
  output logic                         out_valid,
  output ibs_pkg::out_t                out_data
);

  localparam int AW = $clog2(MAX_ELEMS);

  logic [ibs_pkg::DATA_W-1:0]        rd_data;
  logic [ibs_pkg::DATA_W-1:0]        wr_data;
  logic signed [ibs_pkg::DATA_W-1:0] carry_r;
  logic signed [ibs_pkg::DATA_W-1:0] carry_nxt;
  logic                              gt;
  ibs_pkg::out_t                     out_data_r;
  ibs_pkg::out_t                     out_data_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;

  // element buffer
  ibs_ram #(
    .WIDTH (ibs_pkg::DATA_W),
    .DEPTH (MAX_ELEMS)
  ) u_buf (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (ram_waddr[AW-1:0]),
    .wdata (wr_data),
    .re    (cmd.ram_re),
    .raddr (ram_raddr[AW-1:0]),
    .rdata (rd_data)
  );

  // running maximum of the pass against the element just read
  assign gt = carry_r > $signed(rd_data);

  // write data select: new element, smaller of the pair, or pass maximum
  always_comb begin
    unique case (cmd.wsel)
      ibs_pkg::WSEL_IN:    wr_data = in_value;
      ibs_pkg::WSEL_MIN:   wr_data = gt ? rd_data : carry_r;
      ibs_pkg::WSEL_CARRY: wr_data = carry_r;
      default:             wr_data = carry_r;
    endcase
  end

  // carry keeps the larger value; equal values move on so the sort stays stable
  always_comb begin
    carry_nxt = carry_r;
    if (cmd.carry_first) begin
      carry_nxt = $signed(rd_data);
    end else if (cmd.carry_step && !gt) begin
      carry_nxt = $signed(rd_data);
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
  end

  // result register
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_data_nxt.sorted_value = $signed(rd_data);
      out_data_nxt.last_result  = cmd.out_last;
      out_data_nxt.overflowed   = cmd.out_ovf;
      out_valid_nxt             = 1'b1;
    end else if (cmd.out_clear) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/ibs_ctrl.sv -----
// controller: load, bubble pass and emit sequencing with element counters
// depends on ibs_pkg
module ibs_ctrl #(
  parameter int MAX_ELEMS = ibs_pkg::MAX_ELEMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_last,
  output logic                         in_stall,
  input  logic                         out_stall,
  output ibs_pkg::dp_cmd_t             cmd,
  output logic [$clog2(MAX_ELEMS)-1:0] ram_waddr,
  output logic [$clog2(MAX_ELEMS)-1:0] ram_raddr
);

  localparam int AW = $clog2(MAX_ELEMS);
  localparam int CW = $clog2(MAX_ELEMS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMS);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);

  typedef enum logic [7:0] {
    ST_LOAD   = 8'b0000_0001,
    ST_PSTART = 8'b0000_0010,
    ST_PFIRST = 8'b0000_0100,
    ST_PRUN   = 8'b0000_1000,
    ST_PEND   = 8'b0001_0000,
    ST_ERD    = 8'b0010_0000,
    ST_ELD    = 8'b0100_0000,
    ST_EOUT   = 8'b1000_0000
  } state_t;

  state_t        state_r;
  state_t        state_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          ovf_r;
  logic          ovf_nxt;
  logic [CW-1:0] pass_len_r;
  logic [CW-1:0] pass_len_nxt;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] idx_nxt;
  logic          in_xfer;
  logic          room;
  logic [CW-1:0] n_after;
  logic [CW-1:0] idx_plus1;

  assign in_stall  = (state_r != ST_LOAD);
  assign in_xfer   = in_valid && !in_stall;
  assign room      = (count_r < MAX_C);
  assign n_after   = room ? CW'(count_r + ONE_C) : count_r;
  assign idx_plus1 = CW'(CW'(idx_r) + ONE_C);

  // next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    pass_len_nxt = pass_len_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    cmd.wsel     = ibs_pkg::WSEL_IN;
    ram_waddr    = '0;
    ram_raddr    = '0;

    unique case (state_r)
      // store incoming elements, drop them once full
      ST_LOAD: begin
        if (in_xfer) begin
          if (room) begin
            cmd.ram_we = 1'b1;
            cmd.wsel   = ibs_pkg::WSEL_IN;
            ram_waddr  = count_r[AW-1:0];
            count_nxt  = n_after;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            pass_len_nxt = n_after;
            idx_nxt      = '0;
            state_nxt    = (n_after >= TWO_C) ? ST_PSTART : ST_ERD;
          end
        end
      end

      // read the first element of a pass
      ST_PSTART: begin
        cmd.ram_re = 1'b1;
        ram_raddr  = '0;
        state_nxt  = ST_PFIRST;
      end

      // first element becomes the carry, fetch the second
      ST_PFIRST: begin
        cmd.carry_first = 1'b1;
        cmd.ram_re      = 1'b1;
        ram_raddr       = AW'(1);
        idx_nxt         = AW'(1);
        state_nxt       = ST_PRUN;
      end

      // one compare-and-swap per cycle, smaller value written one slot back
      ST_PRUN: begin
        cmd.carry_step = 1'b1;
        cmd.ram_we     = 1'b1;
        cmd.wsel       = ibs_pkg::WSEL_MIN;
        ram_waddr      = AW'(idx_r - AW'(1));
        if (idx_plus1 == pass_len_r) begin
          state_nxt = ST_PEND;
        end else begin
          cmd.ram_re = 1'b1;
          ram_raddr  = AW'(idx_r + AW'(1));
          idx_nxt    = AW'(idx_r + AW'(1));
        end
      end

      // pass maximum lands in the last slot of the pass
      ST_PEND: begin
        cmd.ram_we   = 1'b1;
        cmd.wsel     = ibs_pkg::WSEL_CARRY;
        ram_waddr    = AW'(pass_len_r - ONE_C);
        pass_len_nxt = CW'(pass_len_r - ONE_C);
        if (pass_len_r > TWO_C) begin
          state_nxt = ST_PSTART;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_ERD;
        end
      end

      // emit: fetch the next sorted element
      ST_ERD: begin
        cmd.ram_re = 1'b1;
        ram_raddr  = idx_r;
        state_nxt  = ST_ELD;
      end

      // emit: load the result register
      ST_ELD: begin
        cmd.out_load = 1'b1;
        cmd.out_last = (idx_plus1 == count_r);
        cmd.out_ovf  = ovf_r;
        state_nxt    = ST_EOUT;
      end

      // emit: wait for the result transfer
      ST_EOUT: begin
        if (!out_stall) begin
          cmd.out_clear = 1'b1;
          if (idx_plus1 == count_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            idx_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt   = AW'(idx_r + AW'(1));
            state_nxt = ST_ERD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      pass_len_r <= '0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      pass_len_r <= pass_len_nxt;
      idx_r      <= idx_nxt;
    end
  end

endmodule

// ----- rtl/int_bubble_sort.sv -----
// Ascending sort of a framed array of signed 32-bit values. Elements are taken one per cycle
// into a MAX_ELEMS-entry buffer until an item with last_item arrives; elements beyond capacity
// are dropped and every result of that array carries overflowed. The stored n elements are then
// bubble sorted in place through a single buffer memory with one write and one registered read
// port: each pass fills the carry from its first element, then does one compare-and-swap per
// cycle and ends with a final write of the pass maximum; passes run for L = n down to 2. Each
// result is then read, loaded into the result register and held until it has been transferred.
// The input is stalled from the last element until the final result (last_result) has been
// transferred; the block is then ready for the next array.
// depends on ibs_pkg, ibs_ctrl, ibs_dpath, ibs_ram and assert_macros.svh
`include "assert_macros.svh"

module int_bubble_sort #(
  parameter int MAX_ELEMS = ibs_pkg::MAX_ELEMS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ibs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ibs_pkg::out_t out_data
);

  localparam int AW = $clog2(MAX_ELEMS);

  ibs_pkg::dp_cmd_t  dp_cmd;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;

  // sequencing
  ibs_ctrl #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last_item),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .cmd       (dp_cmd),
    .ram_waddr (ram_waddr),
    .ram_raddr (ram_raddr)
  );

  // buffer, compare and result register
  ibs_dpath #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_value  (in_data.value),
    .cmd       (dp_cmd),
    .ram_waddr (ram_waddr),
    .ram_raddr (ram_raddr),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // no element is taken while a result is pending
  `ASSERT_IMPLIES(a_no_load_while_out, clk, rst_n, out_valid, in_stall)

  // the final result transfer frees the input on the next cycle
  `ASSERT_NEXT(a_ready_after_last, clk, rst_n,
               out_valid && !out_stall && out_data.last_result, !in_stall)

  // the sort never reads and writes the same buffer entry in one cycle
  `ASSERT_IMPLIES(a_no_rw_collision, clk, rst_n,
                  dp_cmd.ram_we && dp_cmd.ram_re, ram_waddr != ram_raddr)

endmodule
